>>> sv/bslp_pkg.sv
// shared types and constants for the button press classifier
package bslp_pkg;

  // fixed field widths
  localparam int MASK_W    = 7;
  localparam int TIME_W    = 32;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // default number of button lanes
  localparam int BUTTONS_DEF = 7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_HIGH = 2'd0,
    REG_DEBOUNCE    = 2'd1,
    REG_LONG_PRESS  = 2'd2,
    REG_SPARE       = 2'd3
  } cfg_reg_t;

  // reset values of the registers
  localparam logic [MASK_W-1:0] ACTIVE_HIGH_RST = '0;
  localparam logic [MS_W-1:0]   DEBOUNCE_RST    = 16'd50;
  localparam logic [MS_W-1:0]   LONG_PRESS_RST  = 16'd1000;

  // timing thresholds shared by all lanes
  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] long_press_ms;
  } timing_t;

  // events found by one lane on one beat
  typedef struct packed {
    logic short_evt;
    logic long_evt;
  } lane_evt_t;

endpackage

>>> sv/bslp_lane.sv
// one button lane: hold tracking and short/long press detection
module bslp_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic                           level,
  input  logic                           polarity,
  input  logic [bslp_pkg::TIME_W-1:0]    now_ms,
  input  bslp_pkg::timing_t              timing,
  output bslp_pkg::lane_evt_t            evt
);

  logic                        held_r, held_nxt;
  logic                        long_fired_r, long_fired_nxt;
  logic [bslp_pkg::TIME_W-1:0] start_r;
  logic [bslp_pkg::TIME_W-1:0] elapsed;
  logic                        active;
  logic                        over_long, over_deb;

  // elapsed time wraps modulo 2^32
  assign active    = (level == polarity);
  assign elapsed   = now_ms - start_r;
  assign over_long = elapsed > {{(bslp_pkg::TIME_W-bslp_pkg::MS_W){1'b0}},
                                timing.long_press_ms};
  assign over_deb  = elapsed > {{(bslp_pkg::TIME_W-bslp_pkg::MS_W){1'b0}},
                                timing.debounce_ms};

  // next state and events for this beat
  always_comb begin
    held_nxt       = held_r;
    long_fired_nxt = long_fired_r;
    evt            = '0;
    if (active) begin
      if (!held_r) begin
        held_nxt       = 1'b1;
        long_fired_nxt = 1'b0;
      end else if (!long_fired_r && over_long) begin
        evt.long_evt   = 1'b1;
        long_fired_nxt = 1'b1;
      end
    end else if (held_r) begin
      evt.short_evt = over_deb && !long_fired_r;
      held_nxt      = 1'b0;
    end
  end

  // flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 1'b0;
      long_fired_r <= 1'b0;
    end else if (fire) begin
      held_r       <= held_nxt;
      long_fired_r <= long_fired_nxt;
    end
  end

  // start time, captured when a hold begins
  always_ff @(posedge clk) begin
    if (fire && active && !held_r) begin
      start_r <= now_ms;
    end
  end

endmodule

>>> sv/bslp_merge.sv
// merges lane events into the output masks and holds the result beat
module bslp_merge #(
  parameter int BUTTONS = bslp_pkg::BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [BUTTONS-1:0]            short_vec,
  input  logic [BUTTONS-1:0]            long_vec,
  input  logic                          out_stall,
  output logic                          busy,
  output logic                          out_valid,
  output logic [bslp_pkg::MASK_W-1:0]   out_short_press_mask,
  output logic [bslp_pkg::MASK_W-1:0]   out_long_press_mask
);

  logic                        valid_r;
  logic [bslp_pkg::MASK_W-1:0] short_nxt, long_nxt;
  logic [bslp_pkg::MASK_W-1:0] short_r, long_r;

  // lanes past the field width are dropped, missing lanes read zero
  for (genvar j = 0; j < bslp_pkg::MASK_W; j++) begin : g_pack
    if (j < BUTTONS) begin : g_lane
      assign short_nxt[j] = short_vec[j];
      assign long_nxt[j]  = long_vec[j];
    end else begin : g_none
      assign short_nxt[j] = 1'b0;
      assign long_nxt[j]  = 1'b0;
    end
  end

  // output beat is held while stalled
  assign busy = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      short_r <= short_nxt;
      long_r  <= long_nxt;
    end
  end

  assign out_valid            = valid_r;
  assign out_short_press_mask = short_r;
  assign out_long_press_mask  = long_r;

endmodule

>>> sv/button_short_long_press_classifier.sv
// top level of the button short/long press classifier
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | pin_levels[6:0], now_ms[31:0]
//   out_    | output    | out_valid/out_stall | short_press_mask[6:0], long_press_mask[6:0]
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[15:0]
//
// one sample per cycle while in_stall is low; each result appears in the cycle after its sample beat,
// from the single output register behind the lane stage
// one lane per button, each a subtract and two compares
// rst_n is synchronous: clears hold flags, output valid and the configuration registers
// in_stall follows out_stall only while a result beat is waiting
// cfg_ready is always high
module button_short_long_press_classifier #(
  parameter int BUTTONS = bslp_pkg::BUTTONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bslp_pkg::MASK_W-1:0]       in_pin_levels,
  input  logic [bslp_pkg::TIME_W-1:0]       in_now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bslp_pkg::MASK_W-1:0]       out_short_press_mask,
  output logic [bslp_pkg::MASK_W-1:0]       out_long_press_mask,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bslp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bslp_pkg::CFG_DAT_W-1:0]    cfg_data
);

  logic [bslp_pkg::MASK_W-1:0] active_high_r;
  bslp_pkg::timing_t           timing_r;
  logic                        fire;
  logic                        busy;
  logic [BUTTONS-1:0]          short_vec, long_vec;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r          <= bslp_pkg::ACTIVE_HIGH_RST;
      timing_r.debounce_ms   <= bslp_pkg::DEBOUNCE_RST;
      timing_r.long_press_ms <= bslp_pkg::LONG_PRESS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bslp_pkg::cfg_reg_t'(cfg_index))
        bslp_pkg::REG_ACTIVE_HIGH: active_high_r <= cfg_data[bslp_pkg::MASK_W-1:0];
        bslp_pkg::REG_DEBOUNCE:    timing_r.debounce_ms <= cfg_data;
        bslp_pkg::REG_LONG_PRESS:  timing_r.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat acceptance
  assign in_stall = busy;
  assign fire     = in_valid && !busy;

  // button lanes
  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    logic                lvl, pol;
    bslp_pkg::lane_evt_t evt;

    // lanes past the field width see a low level and low polarity
    if (i < bslp_pkg::MASK_W) begin : g_pin
      assign lvl = in_pin_levels[i];
      assign pol = active_high_r[i];
    end else begin : g_extra
      assign lvl = 1'b0;
      assign pol = 1'b0;
    end

    bslp_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .fire     (fire),
      .level    (lvl),
      .polarity (pol),
      .now_ms   (in_now_ms),
      .timing   (timing_r),
      .evt      (evt)
    );

    assign short_vec[i] = evt.short_evt;
    assign long_vec[i]  = evt.long_evt;
  end

  // merge and output register
  bslp_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk                  (clk),
    .rst_n                (rst_n),
    .fire                 (fire),
    .short_vec            (short_vec),
    .long_vec             (long_vec),
    .out_stall            (out_stall),
    .busy                 (busy),
    .out_valid            (out_valid),
    .out_short_press_mask (out_short_press_mask),
    .out_long_press_mask  (out_long_press_mask)
  );

endmodule
